// ===== hdl/hln_pkg.sv =====
`timescale 1ns / 1ps

package hln_pkg;

	localparam int MaxPixels = 1048576;
	localparam int IdxW      = $clog2(MaxPixels);
	localparam int LenW      = IdxW + 1;
	localparam int PixW      = 8;
	localparam int OffW      = 9;
	localparam int CfgDataW  = 21;
	localparam int CfgIdxW   = 2;
	// span reaches 512 when the offsets sit at -256 and 255
	localparam int SpanW     = OffW + 1;
	localparam int SumW      = 11;
	localparam int HashW     = 32;

	localparam int ModBits   = 4;
	localparam int ModStages = HashW / ModBits;

	localparam logic [HashW-1:0] HashMul1 = 32'h7feb352d;
	localparam logic [HashW-1:0] HashMul2 = 32'h846ca68b;
	localparam logic [HashW-1:0] SeedMul  = 32'd2654435761;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic [CfgIdxW-1:0] CFG_MIN_OFFSET   = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_MAX_OFFSET   = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_FRAME_LENGTH = 2'd2;

	// what travels next to the hash through the pipeline
	typedef struct packed {
		logic [IdxW-1:0] idx;
		logic [PixW-1:0] pixel;
		logic            oor;
	} side_t;

endpackage

// ===== hdl/hln_frame_store.sv =====
`timescale 1ns / 1ps

module hln_frame_store import hln_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             command,
	input  logic [IdxW-1:0]  index,
	input  logic [PixW-1:0]  pixel_in,
	input  logic [LenW-1:0]  frame_len,
	input  logic             down_ready,
	output logic             v_s1,
	output logic [HashW-1:0] x_s1,
	output side_t            side_s1
);

	logic             en_s1;
	logic             accept;
	logic             is_write;
	logic [LenW-1:0]  idx_ext;
	logic [HashW-1:0] len_mix;
	logic [HashW-1:0] seed;
	logic [PixW-1:0]  frame_mem [MaxPixels];
	logic [PixW-1:0]  rdata_q;
	logic [PixW-1:0]  first_q;
	logic [PixW-1:0]  middle_q;
	logic [PixW-1:0]  final_q;
	logic [IdxW-1:0]  idx_s1;
	logic             oor_s1;

	assign en_s1    = !v_s1 || down_ready;
	assign in_stall = !en_s1;
	assign accept   = in_valid && en_s1;
	assign is_write = (command == CMD_WRITE);
	assign idx_ext  = LenW'(index);

	assign len_mix = HashW'(HashW'(frame_len) * SeedMul);
	// latches hold every earlier write, so the seed is current at accept
	assign seed = (HashW'(first_q) << 24) ^ (HashW'(middle_q) << 12) ^
		HashW'(final_q) ^ len_mix;

	// single port: one access per item, write or read
	always_ff @(posedge clk) begin
		if (accept && is_write) begin
			frame_mem[index] <= pixel_in;
		end
		if (accept) begin
			rdata_q <= frame_mem[index];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			middle_q <= '0;
			final_q  <= '0;
		end else if (accept && is_write) begin
			if (index == '0) begin
				first_q <= pixel_in;
			end
			if (idx_ext == (frame_len >> 1)) begin
				middle_q <= pixel_in;
			end
			if (idx_ext == frame_len - LenW'(1)) begin
				final_q <= pixel_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= accept && !is_write;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1 <= index;
			oor_s1 <= (idx_ext >= frame_len);
			x_s1   <= HashW'(index) ^ seed;
		end
	end

	assign side_s1 = '{idx: idx_s1, pixel: rdata_q, oor: oor_s1};

endmodule

// ===== hdl/hln_hash.sv =====
`timescale 1ns / 1ps

module hln_hash import hln_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             v_in,
	input  logic [HashW-1:0] x_in,
	input  side_t            side_in,
	input  logic             down_ready,
	output logic             up_ready,
	output logic             v_s3,
	output logic [HashW-1:0] h_s3,
	output side_t            side_s3
);

	logic             en_s2;
	logic             en_s3;
	logic [HashW-1:0] mix_a;
	logic [HashW-1:0] mix_b;
	logic             v_s2;
	logic [HashW-1:0] h_s2;
	side_t            side_s2;

	assign en_s3    = !v_s3 || down_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign up_ready = en_s2;

	assign mix_a = x_in ^ (x_in >> 16);
	assign mix_b = h_s2 ^ (h_s2 >> 15);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s2) begin
				v_s2 <= v_in;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			h_s2    <= HashW'(mix_a * HashMul1);
			side_s2 <= side_in;
		end
		if (en_s3) begin
			h_s3    <= HashW'(mix_b * HashMul2);
			side_s3 <= side_s2;
		end
	end

endmodule

// ===== hdl/hln_mod.sv =====
`timescale 1ns / 1ps

module hln_mod import hln_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             v_in,
	input  logic [HashW-1:0] h_in,
	input  side_t            side_in,
	input  logic [SpanW-1:0] span,
	input  logic             down_ready,
	output logic             up_ready,
	output logic             v_out,
	output logic [SpanW-1:0] rem_out,
	output side_t            side_out
);

	// restoring remainder, ModBits dividend bits per stage
	function automatic logic [SpanW-1:0] mod_step(
		input logic [SpanW-1:0]   rem,
		input logic [ModBits-1:0] bits,
		input logic [SpanW-1:0]   div
	);
		logic [SpanW:0]   r;
		logic [SpanW-1:0] acc;
		acc = rem;
		for (int i = ModBits - 1; i >= 0; i--) begin
			r = {acc, bits[i]};
			if (r >= {1'b0, div}) begin
				r = r - {1'b0, div};
			end
			acc = r[SpanW-1:0];
		end
		return acc;
	endfunction

	logic             v_s    [ModStages];
	logic [SpanW-1:0] rem_s  [ModStages];
	logic [HashW-1:0] dvd_s  [ModStages];
	side_t            side_s [ModStages];

	logic             v_t    [ModStages+1];
	logic [SpanW-1:0] rem_t  [ModStages+1];
	logic [HashW-1:0] dvd_t  [ModStages+1];
	side_t            side_t_a [ModStages+1];
	logic             en_t   [ModStages+1];

	// last xor-shift of the hash folds into the divider input
	assign v_t[0]      = v_in;
	assign rem_t[0]    = '0;
	assign dvd_t[0]    = h_in ^ (h_in >> 16);
	assign side_t_a[0] = side_in;
	assign en_t[ModStages] = down_ready;

	for (genvar k = 0; k < ModStages; k++) begin : g_stage
		assign en_t[k]       = !v_s[k] || en_t[k+1];
		assign v_t[k+1]      = v_s[k];
		assign rem_t[k+1]    = rem_s[k];
		assign dvd_t[k+1]    = dvd_s[k];
		assign side_t_a[k+1] = side_s[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en_t[k]) begin
				v_s[k] <= v_t[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en_t[k]) begin
				rem_s[k]  <= mod_step(rem_t[k], dvd_t[k][HashW-1 -: ModBits], span);
				dvd_s[k]  <= dvd_t[k] << ModBits;
				side_s[k] <= side_t_a[k];
			end
		end
	end

	assign up_ready = en_t[0];
	assign v_out    = v_t[ModStages];
	assign rem_out  = rem_t[ModStages];
	assign side_out = side_t_a[ModStages];

endmodule

// ===== hdl/hashed_luma_noise.sv =====
`timescale 1ns / 1ps

// channel | direction | handshake            | payload
// cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
// in      | in        | in_valid/in_stall    | command, index, pixel_in
// out     | out       | out_valid/out_stall  | pixel_out, index_out, out_of_range
//
// One item per clock while in_stall is low. A read passes through the
// frame store read, two hash multiplier stages, eight remainder stages and the
// output register. Writes take the single memory port at accept and return nothing.
// Reset clears valid bits, settings and latched pixels, not data or frame store.
// Stalls back up stage by stage, so empty stages fill before in_stall rises.

module hashed_luma_noise import hln_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                command,
	input  logic [IdxW-1:0]     index,
	input  logic [PixW-1:0]     pixel_in,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [PixW-1:0]     pixel_out,
	output logic [IdxW-1:0]     index_out,
	output logic                out_of_range
);

	logic signed [OffW-1:0] min_q;
	logic signed [OffW-1:0] max_q;
	logic [LenW-1:0]        len_q;
	logic [LenW-1:0]        len_new;
	logic signed [OffW-1:0] lo;
	logic signed [OffW-1:0] hi;
	logic [SpanW-1:0]       span;

	logic             fs_v;
	logic [HashW-1:0] fs_x;
	side_t            fs_side;
	logic             hash_ready;
	logic             hash_v;
	logic [HashW-1:0] hash_h;
	side_t            hash_side;
	logic             mod_ready;
	logic             mod_v;
	logic [SpanW-1:0] mod_rem;
	side_t            mod_side;

	logic signed [SumW-1:0] sum;
	logic [PixW-1:0]        clamped;
	logic                   out_en;
	logic                   out_valid_q;
	logic [PixW-1:0]        pixel_out_q;
	logic [IdxW-1:0]        index_out_q;
	logic                   oor_q;

	assign cfg_ready = 1'b1;

	// stored length is already the effective one
	always_comb begin
		if (cfg_data == '0) begin
			len_new = LenW'(1);
		end else if (cfg_data > CfgDataW'(MaxPixels)) begin
			len_new = LenW'(MaxPixels);
		end else begin
			len_new = LenW'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= OffW'(-16);
			max_q <= OffW'(16);
			len_q <= LenW'(MaxPixels);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MIN_OFFSET:   min_q <= cfg_data[OffW-1:0];
				CFG_MAX_OFFSET:   max_q <= cfg_data[OffW-1:0];
				CFG_FRAME_LENGTH: len_q <= len_new;
				default:          ;
			endcase
		end
	end

	always_comb begin
		if (max_q < min_q) begin
			lo = max_q;
			hi = min_q;
		end else begin
			lo = min_q;
			hi = max_q;
		end
		span = SpanW'(SpanW'(hi) - SpanW'(lo) + SpanW'(1));
	end

	hln_frame_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.index      (index),
		.pixel_in   (pixel_in),
		.frame_len  (len_q),
		.down_ready (hash_ready),
		.v_s1       (fs_v),
		.x_s1       (fs_x),
		.side_s1    (fs_side)
	);

	hln_hash u_hash (
		.clk        (clk),
		.arst_n     (arst_n),
		.v_in       (fs_v),
		.x_in       (fs_x),
		.side_in    (fs_side),
		.down_ready (mod_ready),
		.up_ready   (hash_ready),
		.v_s3       (hash_v),
		.h_s3       (hash_h),
		.side_s3    (hash_side)
	);

	hln_mod u_mod (
		.clk        (clk),
		.arst_n     (arst_n),
		.v_in       (hash_v),
		.h_in       (hash_h),
		.side_in    (hash_side),
		.span       (span),
		.down_ready (out_en),
		.up_ready   (mod_ready),
		.v_out      (mod_v),
		.rem_out    (mod_rem),
		.side_out   (mod_side)
	);

	always_comb begin
		sum = $signed({3'b000, mod_side.pixel}) + SumW'(lo) + $signed({1'b0, mod_rem});
		if (sum < 0) begin
			clamped = '0;
		end else if (sum > 255) begin
			clamped = '1;
		end else begin
			clamped = sum[PixW-1:0];
		end
	end

	assign out_en = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= mod_v;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			pixel_out_q <= mod_side.oor ? '0 : clamped;
			index_out_q <= mod_side.idx;
			oor_q       <= mod_side.oor;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_out    = pixel_out_q;
	assign index_out    = index_out_q;
	assign out_of_range = oor_q;

	// input backs up only once the whole pipe is full behind a stalled output
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled with room in the pipeline");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_of_range) |-> (pixel_out == '0))
		else $error("out-of-range read returned a nonzero pixel");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(mod_v))
		else $error("result appeared without an item leaving the divider");

endmodule
